/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the CCQE energy block.
// Simulation gets concurrent assertions; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/ccqe_pkg.sv */
// Types and fixed constants of the CCQE neutrino energy block.
// No dependencies.
package ccqe_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LOW_E    = 2'd1,
    ST_ZERO_MOM = 2'd2,
    ST_ZERO_DEN = 2'd3
  } status_e;

  localparam int unsigned BIND_W     = 17;
  localparam int unsigned MASS_W     = 20;
  localparam int unsigned QUO_W      = 33;
  localparam logic [BIND_W-1:0] BIND_RESET = 17'd30000;
  localparam logic [MASS_W-1:0] NEUTRON_KEV = 20'd939565;
  localparam int unsigned ELECTRON_KEV = 511;
  localparam longint unsigned ELECTRON_SQ = 64'd261121;
  // proton mass squared minus electron mass squared, keV^2
  localparam longint unsigned NUM_CONST = 64'd880354084863;

endpackage

/* hdl/ccqe_neutrino_energy.sv */
// CCQE neutrino energy reconstruction, fully pipelined top level.
// Depends on ccqe_pkg and assert_macros.svh.
//
//  channel  signals                                       dir
//  cfg      cfg_we_i, cfg_wdata_i                         in
//  in       in_valid_i/in_ready_o, mom_x/y/z, lepton_e    in
//  out      out_valid_o/out_ready_i, nu_energy, status    out
//
// One beat per cycle while the output is not stalled. Stages: input,
// product stage, sum stage, one square root stage per root bit, two stages for
// denominator and dividend, overflow check, 33 divider stages, output.
// Reset clears valid bits and loads the binding energy with 30000 keV.
// A stall at the output holds every stage at once; nothing is dropped.
`include "assert_macros.svh"
module ccqe_neutrino_energy import ccqe_pkg::*; #(
  parameter int unsigned FIELD_BITS = 25
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [BIND_W-1:0]            cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [FIELD_BITS-1:0] mom_x_i,
  input  logic signed [FIELD_BITS-1:0] mom_y_i,
  input  logic signed [FIELD_BITS-1:0] mom_z_i,
  input  logic [FIELD_BITS-2:0]        lepton_energy_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [31:0]           nu_energy_o,
  output logic [1:0]                   status_o
);

  localparam int unsigned F       = FIELD_BITS;
  localparam int unsigned SQ_W    = 2 * F;
  localparam int unsigned ME_W    = ((F > 21) ? F : 21) + 1;
  localparam int unsigned NUM_W   = F + 25;
  localparam int unsigned NMAG_W  = F + 24;
  localparam int unsigned MLO_W   = NMAG_W / 2;
  localparam int unsigned MHI_W   = NMAG_W - MLO_W;
  localparam int unsigned NPROD_W = NMAG_W + F;
  localparam int unsigned T1_W    = ME_W + F + 1;
  localparam int unsigned T2_W    = 2 * F + 1;
  localparam int unsigned DEN_W   = T1_W + 1;
  localparam int unsigned DIV_W   = DEN_W + 1;
  localparam int unsigned NHI_W   = NPROD_W - QUO_W;
  localparam int unsigned CMP_W   = (NHI_W > DIV_W) ? NHI_W : DIV_W;
  localparam int unsigned MM_W    = 2 * MASS_W;
  localparam int unsigned ME2_W   = MASS_W + F - 1;

  typedef struct packed {
    logic [SQ_W-1:0] x;
    logic [F+2:0]    rem;
    logic [F-1:0]    root;
  } sqs_t;

  typedef struct packed {
    logic                    low_e;
    logic signed [F-1:0]     pz;
    logic signed [ME_W-1:0]  me;
    logic signed [NUM_W-1:0] num;
  } side_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] d;
    logic [QUO_W-1:0] n;
    logic [QUO_W-1:0] quo;
  } dvs_t;

  typedef struct packed {
    status_e status;
    logic    neg;
    logic    ovf;
  } dside_t;

  function automatic sqs_t sq_step(sqs_t a);
    sqs_t         r;
    logic [F+2:0] cur;
    logic [F+2:0] trial;
    cur   = {a.rem[F:0], a.x[SQ_W-1 -: 2]};
    trial = {1'b0, a.root, 2'b01};
    r.x   = a.x << 2;
    if (cur >= trial) begin
      r.rem  = cur - trial;
      r.root = {a.root[F-2:0], 1'b1};
    end else begin
      r.rem  = cur;
      r.root = {a.root[F-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic dvs_t dv_step(dvs_t a);
    dvs_t           r;
    logic [DIV_W:0] cur;
    cur = {a.rem, a.n[QUO_W-1]};
    r.d = a.d;
    r.n = a.n << 1;
    if (cur >= {1'b0, a.d}) begin
      r.rem = DIV_W'(cur - {1'b0, a.d});
      r.quo = {a.quo[QUO_W-2:0], 1'b1};
    end else begin
      r.rem = DIV_W'(cur);
      r.quo = {a.quo[QUO_W-2:0], 1'b0};
    end
    return r;
  endfunction

  logic               adv;
  logic [BIND_W-1:0]  bind_q;
  logic [MASS_W-1:0]  mass_w;

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;
  assign mass_w     = NEUTRON_KEV - MASS_W'(bind_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bind_q <= BIND_RESET;
    end else if (cfg_we_i) begin
      bind_q <= cfg_wdata_i;
    end
  end

  // input stage
  logic                v0_q;
  logic signed [F-1:0] px0_q, py0_q, pz0_q;
  logic [F-2:0]        e0_q;
  logic [MASS_W-1:0]   m0_q;

  // product stage
  logic                v1_q;
  logic [SQ_W-1:0]     sqx1_q, sqy1_q, sqz1_q, ee1_q;
  logic [MM_W-1:0]     mm1_q;
  logic [ME2_W-1:0]    me21_q;
  logic signed [F-1:0] pz1_q;
  logic [F-2:0]        e1_q;
  logic [MASS_W-1:0]   m1_q;

  logic signed [SQ_W-1:0] pxe, pye, pze;
  assign pxe = SQ_W'(px0_q);
  assign pye = SQ_W'(py0_q);
  assign pze = SQ_W'(pz0_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (in_valid_i) begin
        px0_q <= mom_x_i;
        py0_q <= mom_y_i;
        pz0_q <= mom_z_i;
        e0_q  <= lepton_energy_i;
        m0_q  <= mass_w;
      end
      sqx1_q <= SQ_W'(pxe * pxe);
      sqy1_q <= SQ_W'(pye * pye);
      sqz1_q <= SQ_W'(pze * pze);
      ee1_q  <= SQ_W'(e0_q) * SQ_W'(e0_q);
      mm1_q  <= MM_W'(m0_q) * MM_W'(m0_q);
      me21_q <= ME2_W'(m0_q) * ME2_W'(e0_q);
      pz1_q  <= pz0_q;
      e1_q   <= e0_q;
      m1_q   <= m0_q;
    end
  end

  // square root pipeline: index 0 is the sum stage
  sqs_t  sa_q [F+1];
  sqs_t  sb_q [F+1];
  side_t sd_q [F+1];
  logic  sv_q [F+1];

  logic low_e1;
  assign low_e1 = (e1_q < (F-1)'(ELECTRON_KEV));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else if (adv) begin
      sv_q[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sa_q[0].x    <= sqx1_q + sqy1_q + sqz1_q;
      sa_q[0].rem  <= '0;
      sa_q[0].root <= '0;
      sb_q[0].x    <= low_e1 ? '0 : ee1_q - SQ_W'(ELECTRON_SQ);
      sb_q[0].rem  <= '0;
      sb_q[0].root <= '0;
      sd_q[0].low_e <= low_e1;
      sd_q[0].pz    <= pz1_q;
      sd_q[0].me    <= $signed(ME_W'(m1_q)) - $signed(ME_W'(e1_q));
      sd_q[0].num   <= $signed(NUM_W'(NUM_CONST) - NUM_W'(mm1_q) + (NUM_W'(me21_q) << 1));
    end
  end

  for (genvar i = 0; i < F; i++) begin : g_sqrt
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[i+1] <= 1'b0;
      end else if (adv) begin
        sv_q[i+1] <= sv_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sa_q[i+1] <= sq_step(sa_q[i]);
        sb_q[i+1] <= sq_step(sb_q[i]);
        sd_q[i+1] <= sd_q[i];
      end
    end
  end

  // denominator terms and split dividend product
  logic [F-1:0]            q_w, p_w;
  side_t                   sf_w;
  logic signed [NUM_W-1:0] nabs_w;
  logic [NMAG_W-1:0]       nmag_w;

  assign q_w    = sa_q[F].root;
  assign p_w    = sb_q[F].root;
  assign sf_w   = sd_q[F];
  assign nabs_w = sf_w.num[NUM_W-1] ? -sf_w.num : sf_w.num;
  assign nmag_w = nabs_w[NMAG_W-1:0];

  logic                   vc_q;
  status_e                stc_q;
  logic                   nnegc_q;
  logic [MLO_W+F-1:0]     plo_q;
  logic [MHI_W+F-1:0]     phi_q;
  logic signed [T1_W-1:0] t1_q;
  logic signed [T2_W-1:0] t2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (adv) begin
      vc_q <= sv_q[F];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (sf_w.low_e) begin
        stc_q <= ST_LOW_E;
      end else if (q_w == '0) begin
        stc_q <= ST_ZERO_MOM;
      end else begin
        stc_q <= ST_OK;
      end
      nnegc_q <= sf_w.num[NUM_W-1];
      plo_q   <= (MLO_W+F)'(nmag_w[MLO_W-1:0]) * (MLO_W+F)'(q_w);
      phi_q   <= (MHI_W+F)'(nmag_w[NMAG_W-1:MLO_W]) * (MHI_W+F)'(q_w);
      t1_q    <= T1_W'(sf_w.me) * T1_W'($signed({1'b0, q_w}));
      t2_q    <= T2_W'($signed({1'b0, p_w})) * T2_W'(sf_w.pz);
    end
  end

  // denominator sum, dividend assembly
  logic signed [DEN_W-1:0] den_w, dabs_w;
  assign den_w  = DEN_W'(t1_q) + DEN_W'(t2_q);
  assign dabs_w = den_w[DEN_W-1] ? -den_w : den_w;

  logic               vd_q;
  status_e            std_q;
  logic               negd_q;
  logic [NPROD_W-1:0] nd_q;
  logic [DIV_W-1:0]   dd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (adv) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (stc_q == ST_OK && den_w == '0) begin
        std_q <= ST_ZERO_DEN;
      end else begin
        std_q <= stc_q;
      end
      negd_q <= nnegc_q ^ den_w[DEN_W-1];
      nd_q   <= (NPROD_W'(phi_q) << MLO_W) + NPROD_W'(plo_q);
      dd_q   <= {dabs_w, 1'b0};
    end
  end

  // divider: stage 0 checks for a quotient beyond 33 bits
  dvs_t   dr_q [QUO_W+1];
  dside_t ds_q [QUO_W+1];
  logic   dv_q [QUO_W+1];

  logic [NHI_W-1:0] nhi_w;
  logic             ovf_w;
  assign nhi_w = nd_q[NPROD_W-1:QUO_W];
  assign ovf_w = CMP_W'(nhi_w) >= CMP_W'(dd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (adv) begin
      dv_q[0] <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dr_q[0].rem   <= ovf_w ? '0 : DIV_W'(nhi_w);
      dr_q[0].d     <= dd_q;
      dr_q[0].n     <= nd_q[QUO_W-1:0];
      dr_q[0].quo   <= '0;
      ds_q[0].status <= std_q;
      ds_q[0].neg    <= negd_q;
      ds_q[0].ovf    <= ovf_w;
    end
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[i+1] <= 1'b0;
      end else if (adv) begin
        dv_q[i+1] <= dv_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dr_q[i+1] <= dv_step(dr_q[i]);
        ds_q[i+1] <= ds_q[i];
      end
    end
  end

  // saturate and register the result
  logic [QUO_W-1:0] quo_w;
  dside_t           df_w;
  logic [31:0]      res_w;
  assign quo_w = dr_q[QUO_W].quo;
  assign df_w  = ds_q[QUO_W];

  always_comb begin
    if (df_w.status != ST_OK) begin
      res_w = '0;
    end else if (df_w.neg) begin
      if (df_w.ovf || quo_w > QUO_W'(32'h8000_0000)) begin
        res_w = 32'h8000_0000;
      end else begin
        res_w = 32'd0 - quo_w[31:0];
      end
    end else begin
      if (df_w.ovf || quo_w > QUO_W'(32'h7FFF_FFFF)) begin
        res_w = 32'h7FFF_FFFF;
      end else begin
        res_w = quo_w[31:0];
      end
    end
  end

  logic        out_valid_q;
  logic [31:0] nu_q;
  status_e     st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_q[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nu_q <= res_w;
      st_q <= df_w.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign nu_energy_o = $signed(nu_q);
  assign status_o    = st_q;

  `ASSERT_IMPL(a_flag_zero, clk_i, rst_ni, out_valid_o && (status_o != ST_OK), nu_energy_o == '0)
  `ASSERT_IMPL(a_stall_all, clk_i, rst_ni, out_valid_o && !out_ready_i, !in_ready_o)
  `ASSERT_NEXT(a_div_fill, clk_i, rst_ni, vd_q && adv, dv_q[0])
  `ASSERT_IMPL(a_rem_bound, clk_i, rst_ni, dv_q[QUO_W] && !df_w.ovf && (df_w.status == ST_OK), dr_q[QUO_W].rem < dr_q[QUO_W].d)

endmodule
